// File: hdl/lqm_pkg.sv
// Shared types and constants for the linked queue manager.
// Holds the fixed port widths, operation codes and status codes.
// No dependencies.
`timescale 1ns / 1ps

package lqm_pkg;

   localparam int CMD_W       = 1;
   localparam int QUEUE_SEL_W = 2;
   localparam int ELEM_ID_W   = 6;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 1'b0,
      CMD_REMOVE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_LINKED = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_ABSENT = 2'd3
   } status_type;

endpackage

// File: hdl/lqm_link_ram.sv
// Single write port, single read port memory with registered read data.
// A read that hits the address written at the same edge returns the new data.
// Depends on nothing.
`timescale 1ns / 1ps

module lqm_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/linked_queue_manager.sv
// Top level of the linked queue manager: queue table, element flags and update logic.
// Depends on lqm_pkg and lqm_link_ram.
`timescale 1ns / 1ps

// Usage:
// The request channel (req_valid/req_ready) carries one operation per item:
// append an element at the tail of a queue, or remove an element from a queue.
// The response channel (rsp_valid/rsp_ready) returns one item per request, in
// order: a status code and the addressed queue's count, head and empty flag
// after the operation. A failed operation changes nothing.
// An accepted request is looked up in the link memories at the accepting edge
// and held in the request register; the update stage then applies it and loads
// the response register. One request is accepted every cycle while the response
// side keeps up; the rate is set by the single update stage between the request
// register and the response register.
// Internally each queue is a linear doubly linked list with a head and a tail
// register, which gives the same answers as a ring.
// Reset empties every queue and marks every element free; it takes effect at
// once and no clearing pass is needed.
// When the receiver stalls, the response register holds its item, the update
// stage holds one more, and req_ready drops until the response is taken.
module linked_queue_manager #(
   parameter int NUM_ELEMS  = 64,
   parameter int NUM_QUEUES = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lqm_pkg::CMD_W-1:0]        req_cmd,
   input  logic [lqm_pkg::QUEUE_SEL_W-1:0]  req_queue_sel,
   input  logic [lqm_pkg::ELEM_ID_W-1:0]    req_elem_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [lqm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lqm_pkg::COUNT_W-1:0]      rsp_queue_count,
   output logic [lqm_pkg::ELEM_ID_W-1:0]    rsp_head_elem,
   output logic                             rsp_queue_empty
);

   import lqm_pkg::*;

   localparam int EW        = $clog2(NUM_ELEMS);
   localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW        = $clog2(NUM_ELEMS + 1);
   localparam int ElemRange = 2 ** ELEM_ID_W;
   localparam int QselRange = 2 ** QUEUE_SEL_W;

   // Handshake and stage registers
   logic          s1_valid_ff;
   logic          rsp_valid_ff;
   cmd_type       s1_cmd_ff;
   logic [QW-1:0] s1_q_ff;
   logic [EW-1:0] s1_e_ff;
   logic          s1_adv;
   logic          accept;

   // Queue table and element flags
   logic [EW-1:0]        head_ff  [NUM_QUEUES];
   logic [EW-1:0]        tail_ff  [NUM_QUEUES];
   logic [CW-1:0]        count_ff [NUM_QUEUES];
   logic [NUM_ELEMS-1:0] linked_ff;

   // Response register
   status_type    rsp_status_ff;
   logic [CW-1:0] rsp_count_ff;
   logic [EW-1:0] rsp_head_ff;
   logic          rsp_empty_ff;

   // Request selectors reduced to the configured ranges
   logic [EW-1:0] req_e_wrap;
   logic [QW-1:0] req_q_wrap;

   // Memory ports
   logic [EW-1:0] next_rd;
   logic [EW-1:0] prev_rd;
   logic [QW-1:0] owner_rd;
   logic          next_we;
   logic [EW-1:0] next_wa;
   logic [EW-1:0] next_wd;
   logic          prev_we;
   logic [EW-1:0] prev_wa;
   logic [EW-1:0] prev_wd;
   logic          owner_we;

   // Update stage results
   status_type    status_in;
   logic [CW-1:0] count_in;
   logic [EW-1:0] head_in;
   logic [EW-1:0] tail_in;
   logic          linked_set;
   logic          linked_clr;
   logic          queue_wr;
   logic          commit;

   // Lookup of the current queue and element
   logic [CW-1:0] cur_count;
   logic [EW-1:0] cur_head;
   logic [EW-1:0] cur_tail;
   logic          cur_linked;
   logic [EW-1:0] rm_prev;
   logic [EW-1:0] rm_next;

   assign s1_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign commit    = s1_valid_ff && s1_adv;

   // Constant tables for the selector wrap.
   always_comb begin
      req_e_wrap = '0;
      for (int i = 0; i < ElemRange; i++) begin
         if (req_elem_id == ELEM_ID_W'(i)) begin
            req_e_wrap = EW'(i % NUM_ELEMS);
         end
      end
   end

   always_comb begin
      req_q_wrap = '0;
      for (int i = 0; i < QselRange; i++) begin
         if (req_queue_sel == QUEUE_SEL_W'(i)) begin
            req_q_wrap = QW'(i % NUM_QUEUES);
         end
      end
   end

   lqm_link_ram #(.DEPTH(NUM_ELEMS), .WIDTH(EW)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we && commit),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (accept),
      .rd_addr (req_e_wrap),
      .rd_data (next_rd)
   );

   lqm_link_ram #(.DEPTH(NUM_ELEMS), .WIDTH(EW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we && commit),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (accept),
      .rd_addr (req_e_wrap),
      .rd_data (prev_rd)
   );

   lqm_link_ram #(.DEPTH(NUM_ELEMS), .WIDTH(QW)) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we && commit),
      .wr_addr (s1_e_ff),
      .wr_data (s1_q_ff),
      .rd_en   (accept),
      .rd_addr (req_e_wrap),
      .rd_data (owner_rd)
   );

   assign cur_count  = count_ff[s1_q_ff];
   assign cur_head   = head_ff[s1_q_ff];
   assign cur_tail   = tail_ff[s1_q_ff];
   assign cur_linked = linked_ff[s1_e_ff];

   // The head has no stored predecessor and the tail no stored successor;
   // the tail and head registers stand in for them.
   assign rm_prev = (s1_e_ff == cur_head) ? cur_tail : prev_rd;
   assign rm_next = (s1_e_ff == cur_tail) ? cur_head : next_rd;

   always_comb begin
      status_in  = STAT_OK;
      count_in   = cur_count;
      head_in    = cur_head;
      tail_in    = cur_tail;
      linked_set = 1'b0;
      linked_clr = 1'b0;
      queue_wr   = 1'b0;
      next_we    = 1'b0;
      next_wa    = cur_tail;
      next_wd    = s1_e_ff;
      prev_we    = 1'b0;
      prev_wa    = s1_e_ff;
      prev_wd    = cur_tail;
      owner_we   = 1'b0;
      unique case (s1_cmd_ff)
         CMD_APPEND: begin
            if (cur_linked) begin
               status_in = STAT_LINKED;
            end else begin
               queue_wr   = 1'b1;
               linked_set = 1'b1;
               owner_we   = 1'b1;
               count_in   = cur_count + CW'(1);
               tail_in    = s1_e_ff;
               if (cur_count == '0) begin
                  head_in = s1_e_ff;
               end else begin
                  next_we = 1'b1;
                  prev_we = 1'b1;
               end
            end
         end
         CMD_REMOVE: begin
            if (cur_count == '0) begin
               status_in = STAT_EMPTY;
            end else if (!cur_linked || (owner_rd != s1_q_ff)) begin
               status_in = STAT_ABSENT;
            end else begin
               queue_wr   = 1'b1;
               linked_clr = 1'b1;
               count_in   = cur_count - CW'(1);
               if (cur_count != CW'(1)) begin
                  next_we = 1'b1;
                  next_wa = rm_prev;
                  next_wd = rm_next;
                  prev_we = 1'b1;
                  prev_wa = rm_next;
                  prev_wd = rm_prev;
                  if (s1_e_ff == cur_head) begin
                     head_in = rm_next;
                  end
                  if (s1_e_ff == cur_tail) begin
                     tail_in = rm_prev;
                  end
               end
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         linked_ff    <= '0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (commit && linked_set) begin
            linked_ff[s1_e_ff] <= 1'b1;
         end
         if (commit && linked_clr) begin
            linked_ff[s1_e_ff] <= 1'b0;
         end
         if (commit && queue_wr) begin
            count_ff[s1_q_ff] <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= cmd_type'(req_cmd);
         s1_q_ff   <= req_q_wrap;
         s1_e_ff   <= req_e_wrap;
      end
      if (commit && queue_wr) begin
         head_ff[s1_q_ff] <= head_in;
         tail_ff[s1_q_ff] <= tail_in;
      end
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_in;
         rsp_head_ff   <= (count_in == '0) ? '0 : head_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_count = COUNT_W'(rsp_count_ff);
   assign rsp_head_elem   = ELEM_ID_W'(rsp_head_ff);
   assign rsp_queue_empty = rsp_empty_ff;

endmodule

// File: sim/tb_linked_queue_manager.sv
// Self-checking testbench for linked_queue_manager: appends and removes elements
// across the four queues and checks every response against an in-bench ring model.
// Depends on lqm_pkg and the linked_queue_manager RTL.
`timescale 1ns / 1ps

module tb_linked_queue_manager;
   import lqm_pkg::*;

   localparam int ELEMS  = 64;
   localparam int QUEUES = 4;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic [ELEM_ID_W-1:0] head;
      logic                 empty;
   } queue_outcome_type;

   typedef enum int {MIX_TRAFFIC, FILL_TRAFFIC, DRAIN_TRAFFIC} traffic_mode_type;

   // Ring model of all queues plus the list of outcomes still owed by the block.
   class queue_ring_scoreboard;
      logic [ELEM_ID_W-1:0]   next_elem [ELEMS];
      logic [ELEM_ID_W-1:0]   prev_elem [ELEMS];
      bit                     in_use    [ELEMS];
      logic [QUEUE_SEL_W-1:0] owner_of  [ELEMS];
      logic [ELEM_ID_W-1:0]   head_of   [QUEUES];
      int                     size_of   [QUEUES];
      queue_outcome_type      expected_outcomes [$];
      int                     mismatch_count;
      int                     requests_noted;
      int                     responses_checked;
      int                     peak_size;
      int                     status_hits [4];

      function new();
         foreach (in_use[i]) begin
            in_use[i]    = 0;
            next_elem[i] = '0;
            prev_elem[i] = '0;
            owner_of[i]  = '0;
         end
         foreach (size_of[i]) begin
            size_of[i] = 0;
            head_of[i] = '0;
         end
         foreach (status_hits[i]) status_hits[i] = 0;
         mismatch_count    = 0;
         requests_noted    = 0;
         responses_checked = 0;
         peak_size         = 0;
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      // Applies one accepted item to the model and queues the outcome it owes.
      function void note_request(cmd_type c, logic [QUEUE_SEL_W-1:0] q,
                                 logic [ELEM_ID_W-1:0] e);
         queue_outcome_type    o;
         logic [ELEM_ID_W-1:0] head_e, tail_e, p, n;
         o.status = STAT_OK;
         if (c == CMD_APPEND) begin
            if (in_use[e]) begin
               o.status = STAT_LINKED;
            end else begin
               if (size_of[q] == 0) begin
                  head_of[q]   = e;
                  next_elem[e] = e;
                  prev_elem[e] = e;
               end else begin
                  // The tail sits just before the head on the ring.
                  head_e            = head_of[q];
                  tail_e            = prev_elem[head_e];
                  next_elem[tail_e] = e;
                  prev_elem[e]      = tail_e;
                  prev_elem[head_e] = e;
                  next_elem[e]      = head_e;
               end
               in_use[e]   = 1;
               owner_of[e] = q;
               size_of[q]++;
            end
         end else begin
            if (size_of[q] == 0) begin
               o.status = STAT_EMPTY;
            end else if (!in_use[e] || owner_of[e] != q) begin
               o.status = STAT_ABSENT;
            end else begin
               if (size_of[q] == 1) begin
                  head_of[q] = '0;
               end else begin
                  p            = prev_elem[e];
                  n            = next_elem[e];
                  next_elem[p] = n;
                  prev_elem[n] = p;
                  if (head_of[q] == e) head_of[q] = n;
               end
               in_use[e] = 0;
               size_of[q]--;
            end
         end
         o.count = COUNT_W'(size_of[q]);
         o.empty = (size_of[q] == 0);
         o.head  = o.empty ? '0 : head_of[q];
         expected_outcomes.push_back(o);
         requests_noted++;
         status_hits[o.status]++;
         if (size_of[q] > peak_size) peak_size = size_of[q];
      endfunction

      task check_response(logic [STATUS_W-1:0] s, logic [COUNT_W-1:0] cnt,
                          logic [ELEM_ID_W-1:0] h, logic emp);
         queue_outcome_type o;
         responses_checked++;
         if (expected_outcomes.size() == 0) begin
            report_mismatch("response arrived with no request outstanding");
         end else begin
            o = expected_outcomes.pop_front();
            if (s !== o.status)
               report_mismatch($sformatf("item %0d status %0d, expected %0d",
                                         responses_checked, s, o.status));
            if (cnt !== o.count)
               report_mismatch($sformatf("item %0d queue_count %0d, expected %0d",
                                         responses_checked, cnt, o.count));
            if (h !== o.head)
               report_mismatch($sformatf("item %0d head_elem %0d, expected %0d",
                                         responses_checked, h, o.head));
            if (emp !== o.empty)
               report_mismatch($sformatf("item %0d queue_empty %0b, expected %0b",
                                         responses_checked, emp, o.empty));
         end
      endtask

      function int pick_free();
         int cands [$];
         foreach (in_use[i]) if (!in_use[i]) cands.push_back(i);
         if (cands.size() == 0) return -1;
         return cands[$urandom_range(0, cands.size() - 1)];
      endfunction

      // Picks a linked element whose owner equals q (match set) or differs from it.
      function int pick_linked(int q, bit match);
         int cands [$];
         foreach (in_use[i])
            if (in_use[i] && ((int'(owner_of[i]) == q) == match)) cands.push_back(i);
         if (cands.size() == 0) return -1;
         return cands[$urandom_range(0, cands.size() - 1)];
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd;
   logic [QUEUE_SEL_W-1:0] req_queue_sel;
   logic [ELEM_ID_W-1:0]   req_elem_id;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_W-1:0]     rsp_queue_count;
   logic [ELEM_ID_W-1:0]   rsp_head_elem;
   logic                   rsp_queue_empty;

   queue_ring_scoreboard sb;
   bit                   sender_steady;
   bit                   long_hold_done;

   linked_queue_manager #(
      .NUM_ELEMS  (ELEMS),
      .NUM_QUEUES (QUEUES)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_queue_sel   (req_queue_sel),
      .req_elem_id     (req_elem_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_queue_count (rsp_queue_count),
      .rsp_head_elem   (rsp_head_elem),
      .rsp_queue_empty (rsp_queue_empty)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_linked_queue_manager: errors");
      $finish;
   end

   // Offers one item, after a random gap unless the sender is steady, and holds it until the block takes it.
   task automatic send(cmd_type c, logic [QUEUE_SEL_W-1:0] q, logic [ELEM_ID_W-1:0] e);
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_cmd       = c;
      req_queue_sel = q;
      req_elem_id   = e;
      do @(posedge clock); while (!req_ready);
      sb.note_request(c, q, e);
   endtask

   // Mostly well-formed operations that follow the current traffic mode; the
   // rest are fully random, which yields duplicate appends and bad removes.
   task automatic random_item(traffic_mode_type mode, int fill_q);
      cmd_type c;
      int      q;
      int      e;
      int      pick;
      c = cmd_type'($urandom_range(0, 1));
      q = $urandom_range(0, QUEUES - 1);
      e = $urandom_range(0, ELEMS - 1);
      if ($urandom_range(0, 99) >= 15) begin
         case (mode)
            FILL_TRAFFIC: begin
               pick = sb.pick_free();
               if (pick >= 0) begin
                  c = CMD_APPEND;
                  q = fill_q;
                  e = pick;
               end else begin
                  // Free an element held by another queue so the fill can go on.
                  pick = sb.pick_linked(fill_q, 1'b0);
                  if (pick >= 0) begin
                     c = CMD_REMOVE;
                     e = pick;
                     q = int'(sb.owner_of[pick]);
                  end
               end
            end
            DRAIN_TRAFFIC: begin
               pick = sb.pick_linked(-1, 1'b0);
               if (pick >= 0) begin
                  c = CMD_REMOVE;
                  e = pick;
                  q = int'(sb.owner_of[pick]);
               end
            end
            default: begin
               if ($urandom_range(0, 1) == 1) begin
                  pick = sb.pick_free();
                  if (pick >= 0) begin
                     c = CMD_APPEND;
                     e = pick;
                  end
               end else begin
                  pick = sb.pick_linked(q, 1'b1);
                  if (pick < 0) pick = sb.pick_linked(-1, 1'b0);
                  if (pick >= 0) begin
                     c = CMD_REMOVE;
                     e = pick;
                     q = int'(sb.owner_of[pick]);
                  end
               end
            end
         endcase
      end
      send(c, q[QUEUE_SEL_W-1:0], e[ELEM_ID_W-1:0]);
   endtask

   // Response side: random stall per item, steady stretches, and one long hold
   // that backs the block up until it stops taking requests.
   initial begin
      int stall_left;
      int hold_left;
      bit sink_steady;
      stall_left  = 0;
      hold_left   = 0;
      sink_steady = 0;
      rsp_ready   = 1'b0;
      long_hold_done = 0;
      wait (sb != null);
      @(negedge clock iff !reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_status, rsp_queue_count, rsp_head_elem, rsp_queue_empty);
            if (sb.responses_checked % 60 == 0) sink_steady = ($urandom_range(0, 2) == 0);
            stall_left = sink_steady ? 0 : $urandom_range(0, 12);
            if (!long_hold_done && sb.responses_checked >= 400) begin
               hold_left      = 80;
               long_hold_done = 1;
            end
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      int               random_sent;
      int               burst_len;
      int               fill_q;
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_APPEND;
      req_queue_sel = '0;
      req_elem_id   = '0;
      sender_steady = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-queue removes, duplicate appends, removes of free and
      // foreign elements, and removal of the head, the tail and a middle element.
      send(CMD_REMOVE, 2'd0, 6'd0);
      send(CMD_APPEND, 2'd0, 6'd0);
      send(CMD_APPEND, 2'd0, 6'd63);
      send(CMD_APPEND, 2'd3, 6'd0);
      send(CMD_REMOVE, 2'd1, 6'd63);
      send(CMD_APPEND, 2'd3, 6'd31);
      send(CMD_REMOVE, 2'd3, 6'd0);
      send(CMD_REMOVE, 2'd3, 6'd5);
      send(CMD_APPEND, 2'd0, 6'd5);
      send(CMD_REMOVE, 2'd0, 6'd63);
      send(CMD_REMOVE, 2'd0, 6'd0);
      send(CMD_REMOVE, 2'd0, 6'd5);
      send(CMD_REMOVE, 2'd0, 6'd5);
      send(CMD_APPEND, 2'd2, 6'd42);
      send(CMD_APPEND, 2'd2, 6'd21);
      send(CMD_APPEND, 2'd2, 6'd63);
      send(CMD_APPEND, 2'd2, 6'd63);
      send(CMD_REMOVE, 2'd2, 6'd63);
      send(CMD_REMOVE, 2'd2, 6'd42);
      send(CMD_APPEND, 2'd2, 6'd42);
      send(CMD_REMOVE, 2'd3, 6'd31);
      send(CMD_APPEND, 2'd1, 6'd62);
      send(CMD_REMOVE, 2'd1, 6'd62);
      send(CMD_APPEND, 2'd1, 6'd1);

      // Random bursts; the first one fills a single queue to the whole pool.
      random_sent = 0;
      mode        = FILL_TRAFFIC;
      burst_len   = 150;
      fill_q      = $urandom_range(0, QUEUES - 1);
      while (random_sent < 1280) begin
         sender_steady = ($urandom_range(0, 3) == 0);
         repeat (burst_len) begin
            random_item(mode, fill_q);
            random_sent++;
         end
         mode      = traffic_mode_type'($urandom_range(0, 2));
         burst_len = $urandom_range(40, 130);
         fill_q    = $urandom_range(0, QUEUES - 1);
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (sb.expected_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d operations: %0d ok, %0d already linked, %0d empty, %0d not found.",
               sb.requests_noted, sb.status_hits[STAT_OK], sb.status_hits[STAT_LINKED],
               sb.status_hits[STAT_EMPTY], sb.status_hits[STAT_ABSENT]);
      $display("Largest queue reached %0d elements; long response stall applied: %0b.",
               sb.peak_size, long_hold_done);
      if (sb.mismatch_count == 0) begin
         $display("tb_linked_queue_manager: clean");
      end else begin
         $display("tb_linked_queue_manager: errors");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/lqm_pkg.sv
hdl/lqm_link_ram.sv
hdl/linked_queue_manager.sv
sim/tb_linked_queue_manager.sv
